// ===== hdl/jtl_pkg.sv =====
package jtl_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } jtl_in_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       in_token;
        logic       token_start;
        logic       token_end;
        logic [1:0] token_kind;
        logic       value_closed;
        logic       pending_dropped;
        logic       escape_error;
    } jtl_out_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_VAL  = 2'd3
    } lex_mode_t;

    localparam logic [1:0] KIND_PUNCT = 2'd0;
    localparam logic [1:0] KIND_STR   = 2'd1;
    localparam logic [1:0] KIND_VAL   = 2'd2;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON};
    endfunction

    function automatic logic is_closer(input logic [7:0] c);
        return c inside {CH_RBRACE, CH_RBRACK, CH_COMMA, CH_COLON};
    endfunction

    // tab, lf, vt, ff, cr and space
    function automatic logic is_space(input logic [7:0] c);
        return (c inside {[CH_TAB:CH_CR]}) || (c == CH_SPACE);
    endfunction

endpackage

// ===== hdl/jtl_step.sv =====
module jtl_step (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  jtl_pkg::jtl_in_t item,
    output jtl_pkg::jtl_out_t result
);
    import jtl_pkg::*;

    lex_mode_t mode_reg;
    lex_mode_t mode_next;
    lex_mode_t mode_lex;
    logic [7:0] c;

    assign c = item.data_byte;

    // mode after this byte, before end-of-stream handling
    always_comb begin
        case (mode_reg)
            MODE_IDLE: begin
                if (is_punct(c)) begin
                    mode_lex = MODE_IDLE;
                end else if (c == CH_QUOTE) begin
                    mode_lex = MODE_STR;
                end else if (!is_space(c)) begin
                    mode_lex = MODE_VAL;
                end else begin
                    mode_lex = MODE_IDLE;
                end
            end
            MODE_STR: begin
                if (c == CH_BSLASH) begin
                    mode_lex = MODE_ESC;
                end else if (c == CH_QUOTE) begin
                    mode_lex = MODE_IDLE;
                end else begin
                    mode_lex = MODE_STR;
                end
            end
            MODE_ESC: begin
                mode_lex = MODE_STR;
            end
            MODE_VAL: begin
                if (is_closer(c) || is_space(c)) begin
                    mode_lex = MODE_IDLE;
                end else begin
                    mode_lex = MODE_VAL;
                end
            end
            default: begin
                mode_lex = MODE_IDLE;
            end
        endcase
    end

    always_comb begin
        mode_next = item.last_byte ? MODE_IDLE : mode_lex;
    end

    always_comb begin
        result                 = '0;
        result.byte_out        = c;
        case (mode_reg)
            MODE_IDLE: begin
                if (is_punct(c)) begin
                    result.in_token    = 1'b1;
                    result.token_start = 1'b1;
                    result.token_end   = 1'b1;
                    result.token_kind  = KIND_PUNCT;
                end else if (c == CH_QUOTE) begin
                    result.in_token    = 1'b1;
                    result.token_start = 1'b1;
                    result.token_kind  = KIND_STR;
                end else if (!is_space(c)) begin
                    result.in_token    = 1'b1;
                    result.token_start = 1'b1;
                    result.token_kind  = KIND_VAL;
                end
            end
            MODE_STR: begin
                result.in_token   = 1'b1;
                result.token_kind = KIND_STR;
                result.token_end  = (c == CH_QUOTE);
            end
            MODE_ESC: begin
                result.in_token   = 1'b1;
                result.token_kind = KIND_STR;
            end
            MODE_VAL: begin
                if (is_closer(c)) begin
                    // closer ends the value and is a token of its own
                    result.value_closed = 1'b1;
                    result.in_token     = 1'b1;
                    result.token_start  = 1'b1;
                    result.token_end    = 1'b1;
                    result.token_kind   = KIND_PUNCT;
                end else if (is_space(c)) begin
                    result.value_closed = 1'b1;
                end else begin
                    result.in_token   = 1'b1;
                    result.token_kind = KIND_VAL;
                end
            end
            default: begin
                result.in_token = 1'b0;
            end
        endcase
        if (item.last_byte) begin
            result.pending_dropped = (mode_lex == MODE_STR) || (mode_lex == MODE_VAL);
            result.escape_error    = (mode_lex == MODE_ESC);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else if (step_en) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== hdl/json_token_lexer.sv =====
// registered path: each byte passes the input register, then the result register, before its result transfer
// throughput: one byte per cycle, sustained while the result side keeps m_ready high
// the lexer mode advances as a byte moves from the input register to the result register
// reset (aresetn low, synchronous): both registers empty, lexer mode idle
module json_token_lexer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jtl_pkg::jtl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output jtl_pkg::jtl_out_t m_data
);
    import jtl_pkg::*;

    jtl_in_t  in_reg;
    logic     in_valid_reg;
    jtl_out_t out_reg;
    logic     out_valid_reg;
    jtl_out_t step_result;
    logic     out_free;
    logic     advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    jtl_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

endmodule

// ===== tb/json_token_lexer_tb.sv =====
`timescale 1ns / 1ps

module json_token_lexer_tb;
    import jtl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          RANDOM_ITEMS = 1150;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam logic [7:0] PUNCT_SET [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK,
                                             CH_RBRACK, CH_COMMA, CH_COLON};
    localparam logic [7:0] BLANK_SET [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    class lexer_scoreboard;
        lex_mode_t mode;
        jtl_out_t  expected_marks[$];
        int        n_fail;

        function new();
            mode = MODE_IDLE;
            n_fail = 0;
        endfunction

        static function bit is_delim(logic [7:0] c);
            case (c)
                CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        static function bit is_closer(logic [7:0] c);
            case (c)
                CH_RBRACE, CH_RBRACK, CH_COMMA, CH_COLON: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        static function bit is_blank(logic [7:0] c);
            case (c)
                CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // expected marks for one byte, advances the lexer mode
        function jtl_out_t lex_byte(jtl_in_t t);
            jtl_out_t   r;
            logic [7:0] c;
            c = t.data_byte;
            r = '0;
            r.byte_out = c;
            case (mode)
                MODE_IDLE: begin
                    if (is_delim(c)) begin
                        r.in_token = 1'b1;
                        r.token_start = 1'b1;
                        r.token_end = 1'b1;
                        r.token_kind = KIND_PUNCT;
                    end else if (c == CH_QUOTE) begin
                        r.in_token = 1'b1;
                        r.token_start = 1'b1;
                        r.token_kind = KIND_STR;
                        mode = MODE_STR;
                    end else if (!is_blank(c)) begin
                        r.in_token = 1'b1;
                        r.token_start = 1'b1;
                        r.token_kind = KIND_VAL;
                        mode = MODE_VAL;
                    end
                end
                MODE_STR: begin
                    r.in_token = 1'b1;
                    r.token_kind = KIND_STR;
                    if (c == CH_BSLASH) begin
                        mode = MODE_ESC;
                    end else if (c == CH_QUOTE) begin
                        r.token_end = 1'b1;
                        mode = MODE_IDLE;
                    end
                end
                MODE_ESC: begin
                    r.in_token = 1'b1;
                    r.token_kind = KIND_STR;
                    mode = MODE_STR;
                end
                default: begin
                    if (is_closer(c)) begin
                        // closer ends the value and is a punctuation token itself
                        r.value_closed = 1'b1;
                        r.in_token = 1'b1;
                        r.token_start = 1'b1;
                        r.token_end = 1'b1;
                        r.token_kind = KIND_PUNCT;
                        mode = MODE_IDLE;
                    end else if (is_blank(c)) begin
                        r.value_closed = 1'b1;
                        mode = MODE_IDLE;
                    end else begin
                        r.in_token = 1'b1;
                        r.token_kind = KIND_VAL;
                    end
                end
            endcase
            if (t.last_byte) begin
                if (mode == MODE_STR || mode == MODE_VAL) r.pending_dropped = 1'b1;
                else if (mode == MODE_ESC) r.escape_error = 1'b1;
                mode = MODE_IDLE;
            end
            return r;
        endfunction

        function void note_byte(jtl_in_t t);
            expected_marks.push_back(lex_byte(t));
        endfunction

        function int pending();
            return expected_marks.size();
        endfunction

        function string show(jtl_out_t r);
            return $sformatf({"byte=%h tok=%b start=%b end=%b kind=%0d",
                              " closed=%b dropped=%b escerr=%b"},
                             r.byte_out, r.in_token, r.token_start, r.token_end, r.token_kind,
                             r.value_closed, r.pending_dropped, r.escape_error);
        endfunction

        function void flag(string msg);
            n_fail++;
            if (n_fail <= 10) $display("%s", msg);
        endfunction

        function void check_result(jtl_out_t got);
            jtl_out_t want;
            if (expected_marks.size() == 0) begin
                flag({"result with nothing expected: ", show(got)});
                return;
            end
            want = expected_marks.pop_front();
            if (got.byte_out !== want.byte_out || got.in_token !== want.in_token ||
                got.token_start !== want.token_start || got.token_end !== want.token_end ||
                got.token_kind !== want.token_kind || got.value_closed !== want.value_closed ||
                got.pending_dropped !== want.pending_dropped ||
                got.escape_error !== want.escape_error) begin
                flag({"mismatch at ", $sformatf("%0t", $realtime),
                      "\n  expected ", show(want), "\n  actual   ", show(got)});
            end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    jtl_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    jtl_out_t m_data;

    lexer_scoreboard sb = new();
    int          n_sent = 0;
    bit          no_stall = 1'b0;
    int unsigned n_cycles = 0;
    logic [7:0]  doc_q[$];

    json_token_lexer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= no_stall || ($urandom_range(0, 99) >= 30);
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic ends);
        jtl_in_t t;
        t.data_byte = b;
        t.last_byte = ends;
        no_stall = (n_sent >= 400 && n_sent < 650);
        if (!no_stall && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(t);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], ends && (i == s.len() - 1));
    endtask

    task automatic drain_pause();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // random json-like text: punctuation, strings with escapes, bare values, whitespace
    function automatic void build_doc();
        int         n_tok;
        int         k;
        logic [7:0] c;
        doc_q.delete();
        n_tok = $urandom_range(3, 24);
        repeat (n_tok) begin
            k = $urandom_range(0, 9);
            if (k < 4) begin
                doc_q.push_back(PUNCT_SET[$urandom_range(0, 5)]);
            end else if (k < 6) begin
                doc_q.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        doc_q.push_back(CH_BSLASH);
                        doc_q.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        do c = 8'($urandom_range(0, 255));
                        while (c == CH_QUOTE || c == CH_BSLASH);
                        doc_q.push_back(c);
                    end
                end
                doc_q.push_back(CH_QUOTE);
            end else if (k < 8) begin
                do c = 8'($urandom_range(0, 255));
                while (lexer_scoreboard::is_delim(c) || c == CH_QUOTE ||
                       lexer_scoreboard::is_blank(c));
                doc_q.push_back(c);
                repeat ($urandom_range(0, 5)) begin
                    do c = 8'($urandom_range(0, 255));
                    while (lexer_scoreboard::is_closer(c) || lexer_scoreboard::is_blank(c));
                    doc_q.push_back(c);
                end
            end else begin
                repeat ($urandom_range(1, 3)) doc_q.push_back(BLANK_SET[$urandom_range(0, 5)]);
            end
        end
    endfunction

    initial begin
        int  cut;
        bit  mid_pause_done;
        mid_pause_done = 1'b0;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: punctuation, strings with escape, value endings, whitespace, stream ends
        send_text("{\"k\\\"\":[v ", 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("{[\",", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_text("t]9:5}", 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_VT, 1'b0);
        send_byte(CH_FF, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_text("\"a", 1'b1);
        send_text("x", 1'b1);
        send_text("\"\\", 1'b1);
        send_text("]", 1'b1);

        drain_pause();

        while (n_sent < RANDOM_ITEMS) begin
            if (!mid_pause_done && n_sent >= 700) begin
                drain_pause();
                mid_pause_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 15) begin
                // noise: raw bytes, stream may end anywhere
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                build_doc();
                // sometimes the stream is cut short mid-document
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, doc_q.size() - 1)
                                                  : doc_q.size() - 1;
                for (int i = 0; i <= cut; i++) send_byte(doc_q[i], i == cut);
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
